### hw/rtl/qpr_pkg.sv
// ============================================================================
// qpr_pkg: shared types and constants of the quadrature position and rate block
// Holds the queue item layout, queue status, operation codes and reset values.
// ============================================================================
package qpr_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam logic [15:0] RATE_RESET = 16'd1000;

	localparam logic OP_TICK = 1'b1;
	localparam logic CH_A    = 1'b0;

	localparam logic signed [15:0] DELTA_MAX = 16'sh7fff;
	localparam logic signed [15:0] DELTA_MIN = 16'sh8000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int SPLIT_W = 20;

	typedef struct packed {
		logic               tick;
		logic [31:0]        position;
		logic signed [15:0] delta;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hw/rtl/qpr_front.sv
// ============================================================================
// qpr_front: input classification and position counter
// Accepts beats, updates the position on edges and forms the saturated
// position change on ticks, then pushes one item into the queue.
// ============================================================================
module qpr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             operation,
	input  logic             edge_channel,
	input  logic             level_a,
	input  logic             level_b,
	input  qpr_pkg::q_stat_t stat,
	output logic             push,
	output qpr_pkg::item_t   push_item
);

	logic [31:0]        count_q;
	logic [31:0]        last_q;
	logic [31:0]        cnt_nxt;
	logic [31:0]        diff;
	logic               tick;
	logic               same;
	logic               up;
	logic signed [15:0] delta;

	assign push = in_valid && !stat.full;
	assign tick = (operation == qpr_pkg::OP_TICK);
	assign same = (level_a == level_b);
	assign up   = (edge_channel == qpr_pkg::CH_A) ? !same : same;

	always_comb begin
		cnt_nxt = up ? (count_q + 32'd1) : (count_q - 32'd1);
		diff    = count_q - last_q;
		if ((&diff[31:15]) || !(|diff[31:15])) begin
			delta = signed'(diff[15:0]);
		end else if (diff[31]) begin
			delta = qpr_pkg::DELTA_MIN;
		end else begin
			delta = qpr_pkg::DELTA_MAX;
		end
	end

	always_comb begin
		push_item.tick     = tick;
		push_item.position = tick ? count_q : cnt_nxt;
		push_item.delta    = delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
		end else if (push) begin
			if (tick) begin
				last_q <= count_q;
			end else begin
				count_q <= cnt_nxt;
			end
		end
	end

endmodule

### hw/rtl/qpr_queue.sv
// ============================================================================
// qpr_queue: item queue between front and back
// A small FIFO that lets the front keep taking beats while the back stalls.
// ============================================================================
module qpr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qpr_pkg::item_t   push_item,
	input  logic             pop,
	output qpr_pkg::item_t   head_item,
	output qpr_pkg::q_stat_t stat
);

	qpr_pkg::item_t              entry_q [qpr_pkg::QUEUE_DEPTH];
	logic [qpr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [qpr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [qpr_pkg::QPTR_W:0]    cnt_q;

	assign head_item  = entry_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (qpr_pkg::QPTR_W + 1)'(qpr_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/qpr_avg_div.sv
// ============================================================================
// qpr_avg_div: floor division of the rate sum by the history depth
// Four-stage pipeline: magnitude, reciprocal partial products, quotient
// estimate, and a back-multiply whose remainder corrects the estimate.
// ============================================================================
module qpr_avg_div #(
	parameter int HISTORY_DEPTH = qpr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [32+$clog2(HISTORY_DEPTH)-1:0] sum_in,
	output logic signed [31:0]                        quo
);

	localparam int LOG2 = $clog2(HISTORY_DEPTH);
	localparam int NW   = 32 + LOG2;
	localparam int LO_W = qpr_pkg::SPLIT_W;
	localparam int HI_W = NW - LO_W;
	localparam logic [NW-1:0] RECIP   = NW'((65'd1 << NW) / HISTORY_DEPTH);
	localparam logic [NW-1:0] DEPTH_N = NW'(HISTORY_DEPTH);

	logic [NW-1:0]        sum_u;
	logic [NW-1:0]        n_in;
	logic [NW-1:0]        n_s4, n_s5, n_s6, n_s7;
	logic                 neg_s4, neg_s5, neg_s6, neg_s7;
	logic [2*LO_W-1:0]    pp_ll_s5;
	logic [LO_W+HI_W-1:0] pp_lh_s5;
	logic [LO_W+HI_W-1:0] pp_hl_s5;
	logic [2*HI_W-1:0]    pp_hh_s5;
	logic [2*NW-1:0]      prod_full;
	logic [32:0]          q0_s6, q0_s7;
	logic [NW-1:0]        qd_s7;
	logic [NW-1:0]        rem;
	logic [32:0]          q_fix;
	logic [32:0]          q_sgn;

	assign sum_u = sum_in;
	assign n_in  = sum_in[NW-1] ? (~sum_u + DEPTH_N) : sum_u;

	assign prod_full = ((2*NW)'(pp_hh_s5) << (2*LO_W))
		+ (((2*NW)'(pp_lh_s5) + (2*NW)'(pp_hl_s5)) << LO_W)
		+ (2*NW)'(pp_ll_s5);

	always_comb begin
		rem   = n_s7 - qd_s7;
		q_fix = q0_s7 + 33'(rem >= DEPTH_N);
		q_sgn = neg_s7 ? (33'd0 - q_fix) : q_fix;
		quo   = signed'(q_sgn[31:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4     <= n_in;
			neg_s4   <= sum_in[NW-1];
			pp_ll_s5 <= (2*LO_W)'(n_s4[LO_W-1:0]) * (2*LO_W)'(RECIP[LO_W-1:0]);
			pp_lh_s5 <= (LO_W+HI_W)'(n_s4[LO_W-1:0]) * (LO_W+HI_W)'(RECIP[NW-1:LO_W]);
			pp_hl_s5 <= (LO_W+HI_W)'(n_s4[NW-1:LO_W]) * (LO_W+HI_W)'(RECIP[LO_W-1:0]);
			pp_hh_s5 <= (2*HI_W)'(n_s4[NW-1:LO_W]) * (2*HI_W)'(RECIP[NW-1:LO_W]);
			n_s5     <= n_s4;
			neg_s5   <= neg_s4;
			q0_s6    <= prod_full[NW+32:NW];
			n_s6     <= n_s5;
			neg_s6   <= neg_s5;
			qd_s7    <= NW'(q0_s6) * DEPTH_N;
			q0_s7    <= q0_s6;
			n_s7     <= n_s6;
			neg_s7   <= neg_s6;
		end
	end

endmodule

### hw/rtl/qpr_back.sv
// ============================================================================
// qpr_back: rate history, running sum and result stage
// Pops items in order, scales ticks to a rate, replaces the oldest history
// entry, keeps the running sum and delivers one result beat per item.
// ============================================================================
module qpr_back #(
	parameter int HISTORY_DEPTH = qpr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qpr_pkg::q_stat_t   stat,
	input  qpr_pkg::item_t     head_item,
	output logic               pop,
	input  logic [15:0]        sample_rate_hz,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [31:0] position,
	output logic signed [31:0] filtered_rate
);

	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int SW     = 32 + SLOT_W;

	logic signed [31:0]     hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      slot_nxt;
	logic signed [SW-1:0]   sum_q;
	logic signed [SW-1:0]   sum_nxt;
	logic signed [31:0]     avg_q;

	logic                   en;
	logic                   we;
	logic                   hit;
	logic signed [32:0]     rate_c;
	logic signed [31:0]     quo;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic                   tick_s1, tick_s2, tick_s3, tick_s4, tick_s5, tick_s6, tick_s7;
	logic [31:0]            pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6, pos_s7, pos_s8;
	logic signed [15:0]     delta_s1;
	logic [SLOT_W-1:0]      slot_s1, slot_s2;
	logic signed [31:0]     rd_s1;
	logic                   rdv_s1;
	logic signed [31:0]     rate_s2;
	logic signed [31:0]     old_s2;
	logic signed [SW-1:0]   sum_s3;
	logic signed [31:0]     rate_s8;

	assign en  = !(vld_s8 && out_stall);
	assign pop = en && !stat.empty;
	assign we  = en && vld_s2 && tick_s2;
	assign hit = we && (slot_s2 == slot_q);

	assign slot_nxt = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : (slot_q + 1'b1);
	assign rate_c   = 33'(delta_s1) * signed'({17'd0, sample_rate_hz});
	assign sum_nxt  = sum_q - SW'(old_s2) + SW'(rate_s2);

	assign out_valid     = vld_s8;
	assign position      = signed'(pos_s8);
	assign filtered_rate = rate_s8;

	qpr_avg_div #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_div (
		.clk   (clk),
		.en    (en),
		.sum_in(sum_s3),
		.quo   (quo)
	);

	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[slot_s2] <= rate_s2;
		end
		if (pop) begin
			rd_s1 <= hit ? rate_s2 : hist_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			avg_q      <= '0;
		end else begin
			if (we) begin
				hist_vld_q[slot_s2] <= 1'b1;
				sum_q               <= sum_nxt;
			end
			if (pop && head_item.tick) begin
				slot_q <= slot_nxt;
			end
			if (en && vld_s7 && tick_s7) begin
				avg_q <= quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tick_s1  <= head_item.tick;
			pos_s1   <= head_item.position;
			delta_s1 <= head_item.delta;
			slot_s1  <= slot_q;
			rdv_s1   <= hit || hist_vld_q[slot_q];
			tick_s2  <= tick_s1;
			pos_s2   <= pos_s1;
			slot_s2  <= slot_s1;
			rate_s2  <= rate_c[31:0];
			old_s2   <= rdv_s1 ? rd_s1 : 32'sd0;
			tick_s3  <= tick_s2;
			pos_s3   <= pos_s2;
			sum_s3   <= sum_nxt;
			tick_s4  <= tick_s3;
			pos_s4   <= pos_s3;
			tick_s5  <= tick_s4;
			pos_s5   <= pos_s4;
			tick_s6  <= tick_s5;
			pos_s6   <= pos_s5;
			tick_s7  <= tick_s6;
			pos_s7   <= pos_s6;
			pos_s8   <= pos_s7;
			rate_s8  <= tick_s7 ? quo : avg_q;
		end
	end

endmodule

### hw/rtl/quadrature_position_and_rate.sv
// ============================================================================
// quadrature_position_and_rate: encoder position counter with averaged rate
// Counts quadrature edges and, on sample ticks, averages the scaled position
// change over the last HISTORY_DEPTH ticks.
//
//   channel   direction   signals
//   config    in          wr_en, wr_data
//   input     in          in_valid, in_stall, operation, edge_channel,
//                         level_a, level_b
//   result    out         out_valid, out_stall, position, filtered_rate
//
// One input beat is taken every cycle while in_stall is low, and each yields one result beat.
// A result passes through the queue and then the eight-stage back pipeline,
// which holds the divider in its middle stages.
// Reset clears the position, rate history valid bits, running sum and queue.
// A stalled result holds the back pipeline; the four-entry queue absorbs
// input beats until it fills, then in_stall rises.
// ============================================================================
module quadrature_position_and_rate #(
	parameter int HISTORY_DEPTH = qpr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               edge_channel,
	input  logic               level_a,
	input  logic               level_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position,
	output logic signed [31:0] filtered_rate
);

	logic [15:0]      rate_hz_q;
	qpr_pkg::q_stat_t q_stat;
	qpr_pkg::item_t   push_item;
	qpr_pkg::item_t   head_item;
	logic             q_push;
	logic             q_pop;

	assign in_stall = q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_hz_q <= qpr_pkg::RATE_RESET;
		end else if (wr_en) begin
			rate_hz_q <= wr_data;
		end
	end

	qpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.operation   (operation),
		.edge_channel(edge_channel),
		.level_a     (level_a),
		.level_b     (level_b),
		.stat        (q_stat),
		.push        (q_push),
		.push_item   (push_item)
	);

	qpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (q_pop),
		.head_item(head_item),
		.stat     (q_stat)
	);

	qpr_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (q_stat),
		.head_item     (head_item),
		.pop           (q_pop),
		.sample_rate_hz(rate_hz_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.position      (position),
		.filtered_rate (filtered_rate)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(position) && $stable(filtered_rate)))
		else $error("result beat changed while stalled");
`endif

endmodule
